>>> rtl/sbus_frame_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// sbus frame receiver assertion macros
// shared concurrent assertion forms, clocked on clk with async reset arst_n
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define SBUS_FRAME_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication
`define SBFR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sbfr check failed");

// next-cycle implication
`define SBFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sbfr check failed");

`endif

>>> rtl/sbfr_pkg.sv
// ----------------------------------------------------------------------------
// sbfr_pkg
// constants and types shared by the sbus frame receiver
// ----------------------------------------------------------------------------
package sbfr_pkg;

	localparam int unsigned FRAME_LEN     = 25;
	localparam int unsigned CHAN_COUNT    = 16;
	localparam int unsigned CHAN_W        = 11;
	localparam int unsigned POS_W         = 5;
	localparam int unsigned IDX_W         = 4;
	localparam int unsigned PAYLOAD_BYTES = 22;
	localparam int unsigned BITS_W        = PAYLOAD_BYTES * 8;
	localparam int unsigned FAILSAFE_BYTE = 23;
	localparam int unsigned FAILSAFE_BIT  = 3;

	localparam logic [7:0]  START_BYTE = 8'h0F;
	localparam logic [7:0]  END_BYTE   = 8'h00;
	localparam logic [15:0] GAP_RESET  = 16'd1000;

	localparam logic STATUS_CHAN = 1'b0;
	localparam logic STATUS_BAD  = 1'b1;

	typedef struct packed {
		logic complete;
		logic good;
		logic failsafe;
	} frame_evt_t;

endpackage

>>> rtl/sbfr_assembler.sv
// ----------------------------------------------------------------------------
// sbfr_assembler
// tracks byte position with gap timeout and stores frame bytes
// ----------------------------------------------------------------------------
module sbfr_assembler (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid,
	input  logic                            take,
	input  logic [7:0]                      rx_byte,
	input  logic [15:0]                     elapsed_us,
	input  logic [15:0]                     gap_threshold,
	output sbfr_pkg::frame_evt_t            evt,
	output logic [sbfr_pkg::BITS_W-1:0]     frame_bits
);

	localparam logic [sbfr_pkg::POS_W-1:0] LAST_POS =
		sbfr_pkg::POS_W'(sbfr_pkg::FRAME_LEN - 1);

	logic [sbfr_pkg::POS_W-1:0] pos_q;
	logic [sbfr_pkg::POS_W-1:0] pos_eff;
	logic                       store;
	logic [7:0]                 frame_q [1:sbfr_pkg::FRAME_LEN-2];

	assign pos_eff = (elapsed_us > gap_threshold) ? '0 : pos_q;
	assign store   = (pos_eff != '0) || (rx_byte == sbfr_pkg::START_BYTE);

	assign evt.complete = valid && store && (pos_eff == LAST_POS);
	assign evt.good     = (rx_byte == sbfr_pkg::END_BYTE);
	assign evt.failsafe = frame_q[sbfr_pkg::FAILSAFE_BYTE][sbfr_pkg::FAILSAFE_BIT];

	always_comb begin
		for (int i = 0; i < sbfr_pkg::PAYLOAD_BYTES; i++) begin
			frame_bits[8*i +: 8] = frame_q[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (evt.complete) begin
				pos_q <= '0;
			end else if (store) begin
				pos_q <= pos_eff + 1'b1;
			end else begin
				pos_q <= pos_eff;
			end
		end
	end

	// start byte and end byte are never read back
	always_ff @(posedge clk) begin
		if (take && store && (pos_eff != '0) && (pos_eff != LAST_POS)) begin
			frame_q[pos_eff] <= rx_byte;
		end
	end

endmodule

>>> rtl/sbus_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// sbus_frame_receiver_unit
// decodes 25-byte serial frames into 16 channel results of 11 bits
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | rx_byte, elapsed_us
//  out     | out_valid / out_ready| status, channel_index, channel_value,
//          |                      | failsafe_flag, bad_frame_count, last_of_frame
//  cfg     | cfg_wr_en            | cfg_wr_data (gap threshold)
//
// one byte per cycle: input register, then position/store update.
// a good frame yields 16 beats from the result buffer, one per cycle while
// out_ready is high; a bad end byte yields one beat. input stalls only when
// a frame completes while the buffer still holds the previous frame's beats.
// reset clears position, bad-frame count and buffer; threshold goes to 1000.
module sbus_frame_receiver_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	input  logic [15:0] elapsed_us,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [3:0]  channel_index,
	output logic [10:0] channel_value,
	output logic        failsafe_flag,
	output logic [15:0] bad_frame_count,
	output logic        last_of_frame,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data
);

	localparam logic [sbfr_pkg::IDX_W-1:0] LAST_IDX =
		sbfr_pkg::IDX_W'(sbfr_pkg::CHAN_COUNT - 1);

	logic [15:0]                 gap_threshold_q;
	logic                        valid_s1;
	logic [7:0]                  rx_byte_s1;
	logic [15:0]                 elapsed_s1;
	sbfr_pkg::frame_evt_t        evt;
	logic [sbfr_pkg::BITS_W-1:0] frame_bits;
	logic                        take;
	logic                        advance;
	logic                        buf_free;
	logic                        out_beat;

	logic                        buf_valid_q;
	logic                        buf_bad_q;
	logic                        buf_fs_q;
	logic [15:0]                 buf_count_q;
	logic [sbfr_pkg::BITS_W-1:0] buf_bits_q;
	logic [sbfr_pkg::IDX_W-1:0]  idx_q;
	logic [15:0]                 reject_q;

	assign out_beat = out_valid && out_ready;
	assign buf_free = !buf_valid_q || (out_beat && last_of_frame);
	assign advance  = !evt.complete || buf_free;
	assign take     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_threshold_q <= sbfr_pkg::GAP_RESET;
		end else if (cfg_wr_en) begin
			gap_threshold_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			rx_byte_s1 <= rx_byte;
			elapsed_s1 <= elapsed_us;
		end
	end

	sbfr_assembler u_assembler (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid         (valid_s1),
		.take          (take),
		.rx_byte       (rx_byte_s1),
		.elapsed_us    (elapsed_s1),
		.gap_threshold (gap_threshold_q),
		.evt           (evt),
		.frame_bits    (frame_bits)
	);

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			buf_bad_q   <= 1'b0;
			idx_q       <= '0;
			reject_q    <= '0;
		end else if (take && evt.complete) begin
			buf_valid_q <= 1'b1;
			buf_bad_q   <= !evt.good;
			idx_q       <= '0;
			if (!evt.good) begin
				reject_q <= reject_q + 16'd1;
			end
		end else if (out_beat) begin
			if (last_of_frame) begin
				buf_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && evt.complete) begin
			buf_fs_q    <= evt.failsafe && evt.good;
			buf_bits_q  <= frame_bits;
			buf_count_q <= evt.good ? reject_q : (reject_q + 16'd1);
		end
	end

	assign out_valid       = buf_valid_q;
	assign status          = buf_bad_q ? sbfr_pkg::STATUS_BAD : sbfr_pkg::STATUS_CHAN;
	assign channel_index   = buf_bad_q ? '0 : idx_q;
	assign channel_value   = buf_bad_q ? '0 :
		buf_bits_q[sbfr_pkg::CHAN_W*idx_q +: sbfr_pkg::CHAN_W];
	assign failsafe_flag   = buf_fs_q;
	assign bad_frame_count = buf_count_q;
	assign last_of_frame   = buf_bad_q || (idx_q == LAST_IDX);

`include "sbus_frame_receiver_unit_assert.svh"

	`SBFR_ASSERT_NOW(a_bad_is_single, out_valid && (status == sbfr_pkg::STATUS_BAD), last_of_frame && (channel_index == '0))
	`SBFR_ASSERT_NEXT(a_idx_steps, out_beat && !last_of_frame, out_valid && (channel_index == $past(channel_index) + 4'd1))
	`SBFR_ASSERT_NEXT(a_drain_idle, out_beat && last_of_frame && !(take && evt.complete), !out_valid)
	`SBFR_ASSERT_NOW(a_no_overrun, buf_valid_q && !buf_free, !(take && evt.complete))

endmodule

>>> tb/tb_sbus_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// tb_sbus_frame_receiver_unit
// Feeds serial bytes with inter-byte times into the frame receiver. A frame
// decoder in the bench predicts the channel and bad-frame beats, and each
// output beat is compared with the oldest prediction. The gap threshold is
// changed per phase, both handshakes throttled at random but in phase 2.
// ----------------------------------------------------------------------------
typedef struct packed {
	logic        status;
	logic [3:0]  idx;
	logic [10:0] value;
	logic        failsafe;
	logic [15:0] bad_count;
	logic        last;
} beat_t;

typedef enum int {FRAME_GOOD, FRAME_BAD, FRAME_CUT, NOISE} burst_kind_t;

class frame_decode_model;
	logic [7:0]  frame_bytes [sbfr_pkg::FRAME_LEN];
	logic [4:0]  fill;
	logic [15:0] reject_total;
	logic [15:0] gap_limit;
	beat_t       expected_beats [$];
	int unsigned mismatches;

	function new();
		fill = '0;
		reject_total = '0;
		gap_limit = sbfr_pkg::GAP_RESET;
		mismatches = 0;
	endfunction

	function void take_byte(logic [7:0] b, logic [15:0] dt);
		logic [sbfr_pkg::BITS_W-1:0] bits;
		beat_t r;
		if (dt > gap_limit)
			fill = '0;
		if (fill > 0 || b == sbfr_pkg::START_BYTE) begin
			frame_bytes[fill] = b;
			fill++;
		end
		if (fill != sbfr_pkg::FRAME_LEN)
			return;
		fill = '0;
		if (frame_bytes[0] == sbfr_pkg::START_BYTE &&
			frame_bytes[sbfr_pkg::FRAME_LEN-1] == sbfr_pkg::END_BYTE) begin
			for (int i = 0; i < sbfr_pkg::PAYLOAD_BYTES; i++)
				bits[8*i +: 8] = frame_bytes[1+i];
			for (int ch = 0; ch < sbfr_pkg::CHAN_COUNT; ch++) begin
				r.status = sbfr_pkg::STATUS_CHAN;
				r.idx = 4'(ch);
				r.value = bits[sbfr_pkg::CHAN_W*ch +: sbfr_pkg::CHAN_W];
				r.failsafe = frame_bytes[sbfr_pkg::FAILSAFE_BYTE][sbfr_pkg::FAILSAFE_BIT];
				r.bad_count = reject_total;
				r.last = (ch == sbfr_pkg::CHAN_COUNT - 1);
				expected_beats.push_back(r);
			end
		end else begin
			reject_total++;
			r = '0;
			r.status = sbfr_pkg::STATUS_BAD;
			r.bad_count = reject_total;
			r.last = 1'b1;
			expected_beats.push_back(r);
		end
	endfunction

	function void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function void match_beat(beat_t got);
		beat_t want;
		if (expected_beats.size() == 0) begin
			$display("%0t: unexpected beat status %0d channel %0d value %0d",
				$time, got.status, got.idx, got.value);
			mismatches++;
			return;
		end
		want = expected_beats.pop_front();
		check_field("status", want.status, got.status);
		check_field("channel_index", want.idx, got.idx);
		check_field("channel_value", want.value, got.value);
		check_field("failsafe_flag", want.failsafe, got.failsafe);
		check_field("bad_frame_count", want.bad_count, got.bad_count);
		check_field("last_of_frame", want.last, got.last);
	endfunction
endclass

module tb_sbus_frame_receiver_unit;

	localparam int STALL_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int PHASE_BYTES = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic [15:0] elapsed_us;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic [3:0]  channel_index;
	logic [10:0] channel_value;
	logic        failsafe_flag;
	logic [15:0] bad_frame_count;
	logic        last_of_frame;
	logic        cfg_wr_en;
	logic [15:0] cfg_wr_data;

	frame_decode_model decoder;
	logic        throttle;
	logic        mid_frame;
	logic        bad_sent;
	int          sent_bytes;
	int          stall_cycles;
	logic [15:0] phase_limits [5];

	sbus_frame_receiver_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.rx_byte        (rx_byte),
		.elapsed_us     (elapsed_us),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.channel_index  (channel_index),
		.channel_value  (channel_value),
		.failsafe_flag  (failsafe_flag),
		.bad_frame_count(bad_frame_count),
		.last_of_frame  (last_of_frame),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= throttle ? ($urandom_range(0, 99) >= 29) : 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			decoder.match_beat({status, channel_index, channel_value, failsafe_flag,
				bad_frame_count, last_of_frame});
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic logic [15:0] near_dt();
		if ($urandom_range(0, 9) == 0)
			return decoder.gap_limit;
		return 16'($urandom_range(0, decoder.gap_limit));
	endfunction

	function automatic logic [15:0] gap_dt();
		return 16'($urandom_range(int'(decoder.gap_limit) + 1, 65535));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic [15:0] dt);
		@(negedge clk);
		while (throttle && $urandom_range(0, 99) < 29) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		elapsed_us <= dt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		decoder.take_byte(b, dt);
		sent_bytes++;
	endtask

	task automatic send_frame(input burst_kind_t kind);
		int cut_at;
		send_byte(sbfr_pkg::START_BYTE, mid_frame ? gap_dt() : 16'($urandom_range(0, 65535)));
		mid_frame = 1'b1;
		if (kind == FRAME_CUT) begin
			cut_at = $urandom_range(1, sbfr_pkg::FRAME_LEN - 2);
			for (int i = 0; i < cut_at; i++)
				send_byte(8'($urandom_range(0, 255)), near_dt());
			return;
		end
		for (int i = 1; i < sbfr_pkg::FRAME_LEN - 1; i++)
			send_byte(8'($urandom_range(0, 255)), near_dt());
		send_byte(kind == FRAME_GOOD ? sbfr_pkg::END_BYTE : 8'($urandom_range(1, 255)),
			near_dt());
		mid_frame = 1'b0;
	endtask

	task automatic send_noise();
		logic [7:0] b;
		repeat ($urandom_range(1, 3)) begin
			do
				b = 8'($urandom_range(0, 255));
			while (b == sbfr_pkg::START_BYTE);
			send_byte(b, mid_frame ? gap_dt() : 16'($urandom_range(0, 65535)));
			mid_frame = 1'b0;
		end
	endtask

	task automatic send_random_burst();
		burst_kind_t kind;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			kind = FRAME_GOOD;
		else if (pick < 75)
			kind = FRAME_BAD;
		else if (pick < 88)
			kind = FRAME_CUT;
		else
			kind = NOISE;
		if (!bad_sent)
			kind = FRAME_BAD;
		if (kind == FRAME_CUT && decoder.gap_limit == 16'hFFFF)
			kind = FRAME_GOOD;
		if (kind == FRAME_BAD)
			bad_sent = 1'b1;
		if (kind == NOISE && !(mid_frame && decoder.gap_limit == 16'hFFFF))
			send_noise();
		else
			send_frame(kind == NOISE ? FRAME_GOOD : kind);
	endtask

	task automatic wait_for_decodes();
		@(negedge clk);
		in_valid <= 1'b0;
		while (decoder.expected_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_gap_limit(input logic [15:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		decoder.gap_limit = value;
	endtask

	initial begin
		int phase_start;
		decoder = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = '0;
		elapsed_us = '0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		throttle = 1'b1;
		mid_frame = 1'b0;
		bad_sent = 1'b0;
		sent_bytes = 0;
		stall_cycles = 0;
		phase_limits = '{sbfr_pkg::GAP_RESET, 16'h0000, 16'hFFFF,
			16'($urandom_range(1, 65534)), sbfr_pkg::GAP_RESET};
		repeat (9)
			@(negedge clk);
		arst_n = 1'b1;

		// bytes outside a frame are dropped
		send_byte(8'hF0, 16'hFFFF);
		send_byte(8'h00, 16'h0000);
		// partial frame abandoned by a gap, the gap byte restarts the frame
		send_byte(sbfr_pkg::START_BYTE, 16'h0000);
		repeat (3)
			send_byte(8'hFF, sbfr_pkg::GAP_RESET);
		send_byte(sbfr_pkg::START_BYTE, sbfr_pkg::GAP_RESET + 16'd1);
		// all-ones payload at the threshold boundary, failsafe set
		repeat (sbfr_pkg::PAYLOAD_BYTES)
			send_byte(8'hFF, sbfr_pkg::GAP_RESET);
		send_byte(8'h08, sbfr_pkg::GAP_RESET);
		send_byte(sbfr_pkg::END_BYTE, sbfr_pkg::GAP_RESET);

		for (int p = 0; p < 5; p++) begin
			if (p > 0) begin
				wait_for_decodes();
				write_gap_limit(phase_limits[p]);
			end
			throttle = (p != 2);
			phase_start = sent_bytes;
			while (sent_bytes - phase_start < PHASE_BYTES || mid_frame)
				send_random_burst();
		end

		wait_for_decodes();
		if (decoder.expected_beats.size() != 0)
			$display("%0t: %0d expected beats never arrived", $time,
				decoder.expected_beats.size());
		if (decoder.mismatches == 0 && decoder.expected_beats.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sbfr_pkg.sv
rtl/sbfr_assembler.sv
rtl/sbus_frame_receiver_unit.sv
tb/tb_sbus_frame_receiver_unit.sv
